// ----- design/qnl_pkg.sv -----
// qnl_pkg: shared constants for the quaternion nlerp pipeline.
// No dependencies.
`default_nettype none
package qnl_pkg;
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 14;
    localparam int WEIGHT_BITS        = 16;
    localparam int NORM_TOP           = 29;
    localparam int MAG_BITS           = 30;
    localparam int SUM_BITS           = 62;
    localparam int ROOT_BITS          = 31;
endpackage
`default_nettype wire

// ----- design/quaternion_nlerp.sv -----
// quaternion_nlerp: pipelined normalized linear interpolation of two quaternions.
// Depends on qnl_pkg.
//
//  channel | dir | tdata (low bit first)                        | tuser
//  s_      | in  | a_w a_x a_y a_z b_w b_x b_y b_z blend       | -
//  m_      | out | out_w out_x out_y out_z                     | degenerate
//
// One word per cycle unless m_ stalls; 71+FRACTION_BITS register stages (85 at the
// defaults): seven front stages, 31 square root stages, one dividend stage,
// 31+FRACTION_BITS quotient stages and the output register.
// The square root and the four quotients are restoring units unrolled one bit a stage.
// Reset clears only the valid bits. A stall on m_ freezes every stage at once.
`default_nettype none
module quaternion_nlerp #(
    parameter int COMPONENT_BITS = qnl_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = qnl_pkg::FRACTION_BITS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend, zero fill
    input  wire  [((8*COMPONENT_BITS+16+7)/8)*8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // out_w, out_x, out_y, out_z, zero fill
    output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_tdata,
    // degenerate
    output logic                                 m_tuser
);
    import qnl_pkg::*;
    localparam int CB  = COMPONENT_BITS;
    localparam int PB  = CB + 17;          // a*w product width, signed
    localparam int CW  = PB + 1;           // blend width
    localparam int MW  = CW;               // magnitude before shift
    localparam int SHW = $clog2(MW + MAG_BITS + 1) + 1;
    localparam int QN  = MAG_BITS + FRACTION_BITS;  // dividend bits
    localparam int QW  = QN + 1;
    localparam int NS  = ROOT_BITS;        // sqrt stages
    localparam int OW  = ((4 * CB + 7) / 8) * 8;

    logic adv;
    assign adv = m_tready || !m_tvalid;
    assign s_tready = adv;

    // stage 1: clamp, products
    logic                       v1_reg;
    logic signed [CB-1:0]       a1_reg [4];
    logic signed [CB-1:0]       b1_reg [4];
    logic signed [2*CB-1:0]     d1_reg [4];
    logic [WEIGHT_BITS:0]       t1_reg;
    logic [WEIGHT_BITS:0]       u1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
        if (adv) begin
            logic [WEIGHT_BITS-1:0] t;
            logic [WEIGHT_BITS:0]   tc;
            t  = s_tdata[8*CB +: WEIGHT_BITS];
            tc = (t > 16'h8000) ? 17'h08000 : {1'b0, t};
            t1_reg <= tc;
            u1_reg <= 17'h08000 - tc;
            for (int i = 0; i < 4; i++) begin
                a1_reg[i] <= $signed(s_tdata[i*CB +: CB]);
                b1_reg[i] <= $signed(s_tdata[(4+i)*CB +: CB]);
                d1_reg[i] <= $signed(s_tdata[i*CB +: CB]) * $signed(s_tdata[(4+i)*CB +: CB]);
            end
        end
    end

    // stage 2: dot sign, weighted products
    logic                   v2_reg, sub2_reg;
    logic signed [PB-1:0]   pa2_reg [4];
    logic signed [PB-1:0]   pb2_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            logic signed [2*CB+2:0] dot;
            dot = '0;
            for (int i = 0; i < 4; i++) dot = dot + (2*CB+3)'(d1_reg[i]);
            sub2_reg <= dot[2*CB+2];
            for (int i = 0; i < 4; i++) begin
                pa2_reg[i] <= $signed(a1_reg[i]) * $signed({1'b0, u1_reg});
                pb2_reg[i] <= $signed(b1_reg[i]) * $signed({1'b0, t1_reg});
            end
        end
    end

    // stage 3: blend, magnitudes
    logic               v3_reg;
    logic [3:0]         neg3_reg;
    logic [MW-1:0]      m3_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            logic signed [CW-1:0] c;
            for (int i = 0; i < 4; i++) begin
                c = sub2_reg ? CW'(pa2_reg[i]) - CW'(pb2_reg[i])
                             : CW'(pa2_reg[i]) + CW'(pb2_reg[i]);
                neg3_reg[i] <= c[CW-1];
                m3_reg[i]   <= c[CW-1] ? MW'(-c) : MW'(c);
            end
        end
    end

    // stage 4: OR of the magnitudes and its leading-one position
    logic               v4_reg, z4_reg;
    logic [3:0]         neg4_reg;
    logic [MW-1:0]      m4_reg [4];
    logic [SHW-1:0]     lz4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            logic [MW-1:0] o;
            logic [SHW-1:0] p;
            o = m3_reg[0] | m3_reg[1] | m3_reg[2] | m3_reg[3];
            p = '0;
            for (int k = 0; k < MW; k++) if (o[k]) p = SHW'(k);
            lz4_reg  <= p;
            z4_reg   <= (o == '0);
            neg4_reg <= neg3_reg;
            m4_reg   <= m3_reg;
        end
    end

    // stage 5: common shift to put the top bit at NORM_TOP
    logic               v5_reg, z5_reg;
    logic [3:0]         neg5_reg;
    logic [MAG_BITS-1:0] m5_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
        if (adv) begin
            z5_reg   <= z4_reg;
            neg5_reg <= neg4_reg;
            for (int i = 0; i < 4; i++) begin
                if (lz4_reg > SHW'(NORM_TOP))
                    m5_reg[i] <= MAG_BITS'(m4_reg[i] >> (lz4_reg - SHW'(NORM_TOP)));
                else
                    m5_reg[i] <= MAG_BITS'({m4_reg[i], {MAG_BITS{1'b0}}}
                                 >> (SHW'(MAG_BITS - NORM_TOP) + lz4_reg));
            end
        end
    end

    // stage 6: squares
    logic               v6_reg, z6_reg;
    logic [3:0]         neg6_reg;
    logic [MAG_BITS-1:0] m6_reg [4];
    logic [2*MAG_BITS-1:0] sq6_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= v5_reg;
        if (adv) begin
            z6_reg <= z5_reg; neg6_reg <= neg5_reg; m6_reg <= m5_reg;
            for (int i = 0; i < 4; i++) sq6_reg[i] <= m5_reg[i] * m5_reg[i];
        end
    end

    // stage 7: sum of squares
    logic               v7_reg, z7_reg;
    logic [3:0]         neg7_reg;
    logic [MAG_BITS-1:0] m7_reg [4];
    logic [SUM_BITS-1:0] s7_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (adv) v7_reg <= v6_reg;
        if (adv) begin
            z7_reg <= z6_reg; neg7_reg <= neg6_reg; m7_reg <= m6_reg;
            s7_reg <= SUM_BITS'(sq6_reg[0]) + SUM_BITS'(sq6_reg[1])
                    + SUM_BITS'(sq6_reg[2]) + SUM_BITS'(sq6_reg[3]);
        end
    end

    // square root: one result bit a stage
    logic                v_sq_reg   [NS+1];
    logic                z_sq_reg   [NS+1];
    logic [3:0]          n_sq_reg   [NS+1];
    logic [MAG_BITS-1:0] m_sq_reg   [NS+1][4];
    logic [SUM_BITS+1:0] rem_sq_reg [NS+1];
    logic [ROOT_BITS-1:0] root_sq_reg [NS+1];
    always_comb begin
        v_sq_reg[0] = v7_reg; z_sq_reg[0] = z7_reg; n_sq_reg[0] = neg7_reg;
        m_sq_reg[0] = m7_reg; rem_sq_reg[0] = {2'b0, s7_reg}; root_sq_reg[0] = '0;
    end
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        always_ff @(posedge aclk) begin
            if (!aresetn) v_sq_reg[k+1] <= 1'b0;
            else if (adv) v_sq_reg[k+1] <= v_sq_reg[k];
            if (adv) begin
                logic [SUM_BITS+1:0] trial;
                trial = ({(SUM_BITS+2-ROOT_BITS)'(0), root_sq_reg[k]} << (2*(NS-1-k)+2))
                      | ((SUM_BITS+2)'(1) << (2*(NS-1-k)));
                z_sq_reg[k+1] <= z_sq_reg[k];
                n_sq_reg[k+1] <= n_sq_reg[k];
                m_sq_reg[k+1] <= m_sq_reg[k];
                if (rem_sq_reg[k] >= trial) begin
                    rem_sq_reg[k+1]  <= rem_sq_reg[k] - trial;
                    root_sq_reg[k+1] <= {root_sq_reg[k][ROOT_BITS-2:0], 1'b1};
                end else begin
                    rem_sq_reg[k+1]  <= rem_sq_reg[k];
                    root_sq_reg[k+1] <= {root_sq_reg[k][ROOT_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // dividend with rounding term
    logic                v8_reg, z8_reg;
    logic [3:0]          neg8_reg;
    logic [ROOT_BITS-1:0] r8_reg;
    logic [QW-1:0]       n8_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (adv) v8_reg <= v_sq_reg[NS];
        if (adv) begin
            z8_reg <= z_sq_reg[NS]; neg8_reg <= n_sq_reg[NS];
            r8_reg <= root_sq_reg[NS];
            for (int i = 0; i < 4; i++)
                n8_reg[i] <= ({(QW-MAG_BITS)'(0), m_sq_reg[NS][i]} << FRACTION_BITS)
                           + QW'(root_sq_reg[NS] >> 1);
        end
    end

    // restoring division, one quotient bit a stage
    logic                v_dv_reg [QW+1];
    logic                z_dv_reg [QW+1];
    logic [3:0]          n_dv_reg [QW+1];
    logic [ROOT_BITS-1:0] r_dv_reg [QW+1];
    logic [QW-1:0]       num_dv_reg [QW+1][4];
    logic [ROOT_BITS:0]  rem_dv_reg [QW+1][4];
    always_comb begin
        v_dv_reg[0] = v8_reg; z_dv_reg[0] = z8_reg; n_dv_reg[0] = neg8_reg;
        r_dv_reg[0] = r8_reg; num_dv_reg[0] = n8_reg;
        for (int i = 0; i < 4; i++) rem_dv_reg[0][i] = '0;
    end
    for (genvar k = 0; k < QW; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) v_dv_reg[k+1] <= 1'b0;
            else if (adv) v_dv_reg[k+1] <= v_dv_reg[k];
            if (adv) begin
                logic [ROOT_BITS+1:0] t;
                z_dv_reg[k+1] <= z_dv_reg[k];
                n_dv_reg[k+1] <= n_dv_reg[k];
                r_dv_reg[k+1] <= r_dv_reg[k];
                for (int i = 0; i < 4; i++) begin
                    t = {rem_dv_reg[k][i], num_dv_reg[k][i][QW-1]};
                    if (t >= {2'b0, r_dv_reg[k]}) begin
                        rem_dv_reg[k+1][i] <= (ROOT_BITS+1)'(t - {2'b0, r_dv_reg[k]});
                        num_dv_reg[k+1][i] <= {num_dv_reg[k][i][QW-2:0], 1'b1};
                    end else begin
                        rem_dv_reg[k+1][i] <= (ROOT_BITS+1)'(t);
                        num_dv_reg[k+1][i] <= {num_dv_reg[k][i][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // output register: saturate, sign, zero for degenerate words
    logic [OW-1:0] out_reg;
    logic          deg_reg, vo_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vo_reg <= 1'b0;
        else if (adv) vo_reg <= v_dv_reg[QW];
        if (adv) begin
            logic [QW-1:0] q;
            logic [CB-1:0] o;
            logic [OW-1:0] w;
            w = '0;
            deg_reg <= z_dv_reg[QW];
            for (int i = 0; i < 4; i++) begin
                q = num_dv_reg[QW][i];
                o = (q > QW'({1'b0, {(CB-1){1'b1}}})) ? {1'b0, {(CB-1){1'b1}}} : CB'(q);
                if (n_dv_reg[QW][i]) o = -o;
                if (z_dv_reg[QW]) o = '0;
                w[i*CB +: CB] = o;
            end
            out_reg <= w;
        end
    end
    assign m_tvalid = vo_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = deg_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid) |-> s_tready)
        else $error("input stalled with empty output");
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate word carries nonzero data");
endmodule
`default_nettype wire
